// ===== hdl/avccrp_pkg.sv =====
// Shared types and codes for the AVC configuration record parser.
package avccrp_pkg;

   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = $clog2(QueueDepth);
   localparam int QueueCntW  = $clog2(QueueDepth + 1);

   // Result kind codes
   localparam logic [2:0] KIND_HEADER    = 3'd0;
   localparam logic [2:0] KIND_SPS_BYTE  = 3'd1;
   localparam logic [2:0] KIND_PPS_BYTE  = 3'd2;
   localparam logic [2:0] KIND_PPS_COUNT = 3'd3;
   localparam logic [2:0] KIND_NOT_REC   = 3'd4;
   localparam logic [2:0] KIND_TRUNC     = 3'd5;

   typedef enum logic [3:0] {
      PH_VERSION   = 4'd0,
      PH_PROFILE   = 4'd1,
      PH_COMPAT    = 4'd2,
      PH_LEVEL     = 4'd3,
      PH_LSC       = 4'd4,
      PH_SPS_COUNT = 4'd5,
      PH_LEN_HI    = 4'd6,
      PH_LEN_LO    = 4'd7,
      PH_PAYLOAD   = 4'd8,
      PH_PPS_COUNT = 4'd9,
      PH_SKIP      = 4'd10
   } phase_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] data_byte;
      logic [7:0] set_index;
      logic       unit_end;
      logic [7:0] version;
      logic [7:0] profile;
      logic [7:0] compat;
      logic [7:0] level;
      logic [1:0] length_size_code;
      logic [7:0] set_count;
      logic       out_last;
   } rsp_item_type;

   // Up to two results per accepted byte: the parsed result and a truncation marker
   typedef struct packed {
      logic         valid0;
      logic         valid1;
      rsp_item_type item0;
      rsp_item_type item1;
   } step_out_type;

endpackage

// ===== hdl/avccrp_ifs.sv =====
// Valid/ready channel interfaces for the record bytes and the parsed results.
interface avccrp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface avccrp_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] kind;
   logic [7:0] data_byte;
   logic [7:0] set_index;
   logic       unit_end;
   logic [7:0] version;
   logic [7:0] profile;
   logic [7:0] compat;
   logic [7:0] level;
   logic [1:0] length_size_code;
   logic [7:0] set_count;
   logic       out_last;

   modport source (output valid, output kind, output data_byte, output set_index,
                   output unit_end, output version, output profile, output compat,
                   output level, output length_size_code, output set_count,
                   output out_last, input ready);
   modport sink   (input valid, input kind, input data_byte, input set_index,
                   input unit_end, input version, input profile, input compat,
                   input level, input length_size_code, input set_count,
                   input out_last, output ready);
endinterface

// ===== hdl/avccrp_parser.sv =====
// Record parsing state and per-byte result generation.
module avccrp_parser
   import avccrp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  logic [7:0]   in_byte,
   input  logic         in_last,
   output step_out_type step_out
);

   phase_type   phase_ff, phase_in;
   logic [7:0]  units_left_ff, units_left_in;
   logic [7:0]  unit_number_ff, unit_number_in;
   logic [15:0] bytes_left_ff, bytes_left_in;
   logic [7:0]  length_high_ff, length_high_in;
   logic        in_pps_ff, in_pps_in;
   logic [7:0]  version_ff, version_in;
   logic [7:0]  profile_ff, profile_in;
   logic [7:0]  compat_ff, compat_in;
   logic [7:0]  level_ff, level_in;
   logic [1:0]  lsc_ff, lsc_in;

   logic        done;
   logic        not_record;
   logic        unit_finish;
   logic [7:0]  units_dec;
   logic [15:0] bytes_dec;

   assign units_dec = units_left_ff - 8'd1;
   assign bytes_dec = bytes_left_ff - 16'd1;

   always_comb begin
      phase_in       = phase_ff;
      units_left_in  = units_left_ff;
      unit_number_in = unit_number_ff;
      bytes_left_in  = bytes_left_ff;
      length_high_in = length_high_ff;
      in_pps_in      = in_pps_ff;
      version_in     = version_ff;
      profile_in     = profile_ff;
      compat_in      = compat_ff;
      level_in       = level_ff;
      lsc_in         = lsc_ff;
      step_out       = '0;
      done           = 1'b0;
      not_record     = 1'b0;
      unit_finish    = 1'b0;

      case (phase_ff)
         PH_VERSION: begin
            if (in_byte == 8'd1) begin
               version_in = in_byte;
               profile_in = '0;
               compat_in  = '0;
               level_in   = '0;
               lsc_in     = '0;
               phase_in   = PH_PROFILE;
            end else begin
               not_record              = 1'b1;
               step_out.valid0         = 1'b1;
               step_out.item0.kind     = KIND_NOT_REC;
               step_out.item0.out_last = 1'b1;
               phase_in                = in_last ? PH_VERSION : PH_SKIP;
            end
         end
         PH_PROFILE: begin
            profile_in = in_byte;
            phase_in   = PH_COMPAT;
         end
         PH_COMPAT: begin
            compat_in = in_byte;
            phase_in  = PH_LEVEL;
         end
         PH_LEVEL: begin
            level_in = in_byte;
            phase_in = PH_LSC;
         end
         PH_LSC: begin
            lsc_in   = in_byte[1:0];
            phase_in = PH_SPS_COUNT;
         end
         PH_SPS_COUNT: begin
            step_out.valid0                 = 1'b1;
            step_out.item0.kind             = KIND_HEADER;
            step_out.item0.version          = version_ff;
            step_out.item0.profile          = profile_ff;
            step_out.item0.compat           = compat_ff;
            step_out.item0.level            = level_ff;
            step_out.item0.length_size_code = lsc_ff;
            step_out.item0.set_count        = {3'd0, in_byte[4:0]};
            in_pps_in      = 1'b0;
            unit_number_in = '0;
            units_left_in  = {3'd0, in_byte[4:0]};
            phase_in       = (in_byte[4:0] == 5'd0) ? PH_PPS_COUNT : PH_LEN_HI;
         end
         PH_LEN_HI: begin
            length_high_in = in_byte;
            phase_in       = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            bytes_left_in = {length_high_ff, in_byte};
            if ({length_high_ff, in_byte} == 16'd0) begin
               unit_finish = 1'b1;
            end else begin
               phase_in = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            step_out.valid0          = 1'b1;
            step_out.item0.kind      = in_pps_ff ? KIND_PPS_BYTE : KIND_SPS_BYTE;
            step_out.item0.data_byte = in_byte;
            step_out.item0.set_index = unit_number_ff;
            step_out.item0.unit_end  = (bytes_left_ff == 16'd1);
            bytes_left_in            = bytes_dec;
            unit_finish              = (bytes_dec == 16'd0);
         end
         PH_PPS_COUNT: begin
            step_out.valid0          = 1'b1;
            step_out.item0.kind      = KIND_PPS_COUNT;
            step_out.item0.set_count = in_byte;
            in_pps_in      = 1'b1;
            unit_number_in = '0;
            units_left_in  = in_byte;
            if (in_byte == 8'd0) begin
               phase_in = PH_SKIP;
               done     = 1'b1;
            end else begin
               phase_in = PH_LEN_HI;
            end
         end
         default: begin
            phase_in = PH_SKIP;
         end
      endcase

      // End of one SPS or PPS unit
      if (unit_finish) begin
         units_left_in  = units_dec;
         unit_number_in = unit_number_ff + 8'd1;
         if (units_dec != 8'd0) begin
            phase_in = PH_LEN_HI;
         end else if (!in_pps_ff) begin
            phase_in = PH_PPS_COUNT;
         end else begin
            phase_in = PH_SKIP;
            done     = 1'b1;
         end
      end

      if (done && step_out.valid0) begin
         step_out.item0.out_last = 1'b1;
      end

      // Buffer ended before the record did
      if (in_last && !not_record) begin
         if (phase_in != PH_SKIP) begin
            step_out.valid1         = 1'b1;
            step_out.item1.kind     = KIND_TRUNC;
            step_out.item1.out_last = 1'b1;
         end
         phase_in = PH_VERSION;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_VERSION;
         units_left_ff  <= '0;
         unit_number_ff <= '0;
         bytes_left_ff  <= '0;
         length_high_ff <= '0;
         in_pps_ff      <= 1'b0;
      end else if (accept) begin
         phase_ff       <= phase_in;
         units_left_ff  <= units_left_in;
         unit_number_ff <= unit_number_in;
         bytes_left_ff  <= bytes_left_in;
         length_high_ff <= length_high_in;
         in_pps_ff      <= in_pps_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         version_ff <= version_in;
         profile_ff <= profile_in;
         compat_ff  <= compat_in;
         level_ff   <= level_in;
         lsc_ff     <= lsc_in;
      end
   end

endmodule

// ===== hdl/avccrp_out_queue.sv =====
// Small result queue: takes up to two results a cycle, hands out one.
module avccrp_out_queue
   import avccrp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  step_out_type step_out,
   output logic         space_ok,
   output logic         head_valid,
   output rsp_item_type head_item,
   input  logic         head_ready
);

   rsp_item_type           slot_ff [QueueDepth];
   logic [QueuePtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueueCntW-1:0]   count_ff, count_in;

   logic                   pop;
   logic                   wr_a, wr_b;
   logic [QueuePtrW-1:0]   wr_ptr_b;
   rsp_item_type           item_a;
   logic [QueueCntW-1:0]   n_push;

   assign head_valid = (count_ff != '0);
   assign head_item  = slot_ff[rd_ptr_ff];
   assign pop        = head_valid && head_ready;
   // room for the worst case of two results from one byte
   assign space_ok   = (count_ff <= QueueCntW'(QueueDepth - 2));

   assign wr_a     = push && (step_out.valid0 || step_out.valid1);
   assign wr_b     = push && step_out.valid0 && step_out.valid1;
   assign item_a   = step_out.valid0 ? step_out.item0 : step_out.item1;
   assign wr_ptr_b = wr_ptr_ff + QueuePtrW'(1);
   assign n_push   = QueueCntW'(wr_a) + QueueCntW'(wr_b);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QueuePtrW'(n_push);
      rd_ptr_in = rd_ptr_ff + QueuePtrW'(pop);
      count_in  = count_ff + n_push - QueueCntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_a) begin
         slot_ff[wr_ptr_ff] <= item_a;
      end
      if (wr_b) begin
         slot_ff[wr_ptr_b] <= step_out.item1;
      end
   end

endmodule

// ===== hdl/avc_config_record_parser_core.sv =====
// Top level of the AVC decoder configuration record parser.
//
//  channel | dir | contents                                   | handshake
//  req_ch  | in  | in_byte, in_last                           | valid/ready
//  rsp_ch  | out | kind, data_byte, set_index, unit_end,      | valid/ready
//          |     | header fields, set_count, out_last         |
//
// One record byte is taken per cycle while req_ch.ready is high.
// A byte gives at most two results (a result plus a truncation marker); they
// pass through a 4-entry result queue, and req_ch.ready is high while at least
// two entries are free. One result per byte with rsp_ch ready runs a byte a cycle.
// Synchronous reset empties the queue and returns the parser to the version byte.
module avc_config_record_parser_core
   import avccrp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   avccrp_req_if.sink          req_ch,
   avccrp_rsp_if.source        rsp_ch
);

   logic         accept;
   logic         space_ok;
   step_out_type step_out;
   rsp_item_type head_item;

   assign req_ch.ready = space_ok;
   assign accept       = req_ch.valid && space_ok;

   avccrp_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .in_byte  (req_ch.in_byte),
      .in_last  (req_ch.in_last),
      .step_out (step_out)
   );

   avccrp_out_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .step_out   (step_out),
      .space_ok   (space_ok),
      .head_valid (rsp_ch.valid),
      .head_item  (head_item),
      .head_ready (rsp_ch.ready)
   );

   assign rsp_ch.kind             = head_item.kind;
   assign rsp_ch.data_byte        = head_item.data_byte;
   assign rsp_ch.set_index        = head_item.set_index;
   assign rsp_ch.unit_end         = head_item.unit_end;
   assign rsp_ch.version          = head_item.version;
   assign rsp_ch.profile          = head_item.profile;
   assign rsp_ch.compat           = head_item.compat;
   assign rsp_ch.level            = head_item.level;
   assign rsp_ch.length_size_code = head_item.length_size_code;
   assign rsp_ch.set_count        = head_item.set_count;
   assign rsp_ch.out_last         = head_item.out_last;

endmodule

// ===== hdl/avccrp_checker.sv =====
// Port-level checks for the record parser, bound to the top level.
module avccrp_checker
   import avccrp_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] kind,
   input logic [7:0] data_byte,
   input logic [7:0] version,
   input logic [7:0] set_count,
   input logic       out_last
);

   // queue is empty right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_header_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && kind == KIND_HEADER) |-> !out_last)
      else $error("header item marked last");

   a_error_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (kind == KIND_NOT_REC || kind == KIND_TRUNC)) |-> out_last)
      else $error("error item not marked last");

   a_payload_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (kind == KIND_SPS_BYTE || kind == KIND_PPS_BYTE))
         |-> (version == 8'd0 && set_count == 8'd0))
      else $error("payload item carries header fields");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(kind) && $stable(data_byte)))
      else $error("stalled result changed");

endmodule

bind avc_config_record_parser_core avccrp_checker u_avccrp_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .kind      (rsp_ch.kind),
   .data_byte (rsp_ch.data_byte),
   .version   (rsp_ch.version),
   .set_count (rsp_ch.set_count),
   .out_last  (rsp_ch.out_last)
);
